// File: rtl/core/gdad_pkg.sv
package gdad_pkg;

    // Field widths of one request and one result
    localparam int DAY_W        = 5;
    localparam int MONTH_W      = 4;
    localparam int START_YEAR_W = 15;
    localparam int ADD_W        = 15;
    localparam int YEAR_W       = 16;

    // Day remainder: day + a full leap year + the largest day count
    localparam int REST_W = 16;

    // Calendar constants
    localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
    localparam logic [MONTH_W-1:0] JANUARY         = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY        = 4'd2;
    localparam logic [DAY_W-1:0]   LEAP_FEBRUARY   = 5'd29;

    // Year reduction modulo 400: drop the low four bits (400 = 16 * 25), divide
    // by 25 with a reciprocal multiply, then take off the whole cycles
    localparam int                      CYCLE_YEARS   = 400;
    localparam int                      YEAR_PRESHIFT = 4;
    localparam int                      RECIP_W       = 12;
    localparam logic [RECIP_W-1:0]      RECIP_25      = 12'd2622;
    localparam int                      RECIP_SHIFT   = 16;
    localparam int                      PROD_W        = START_YEAR_W - YEAR_PRESHIFT + RECIP_W;
    localparam int                      QUOT_W        = PROD_W - RECIP_SHIFT;
    localparam int                      SHIFT_W       = 1;
    localparam logic [SHIFT_W-1:0]      SHIFT_START   = 1'b1;
    localparam logic [START_YEAR_W-1:0] CYCLE_LAST    = 15'd399;

    localparam logic [DAY_W-1:0] MONTH_LENGTH [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [DAY_W-1:0]        start_day;
        logic [MONTH_W-1:0]      start_month;
        logic [START_YEAR_W-1:0] start_year;
        logic [ADD_W-1:0]        days_to_add;
    } request_t;

    typedef struct packed {
        logic [DAY_W-1:0]   result_day;
        logic [MONTH_W-1:0] result_month;
        logic [YEAR_W-1:0]  result_year;
    } result_t;

    // Datapath operations selected by the control word
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_REDUCE,
        OP_SUM_ADD,
        OP_SUM_END,
        OP_WALK,
        OP_EMIT
    } op_t;

    // Branch conditions tested by the sequencer
    typedef enum logic [2:0] {
        C_IN_VALID,
        C_K_ZERO,
        C_M_LT,
        C_REST_GT,
        C_OUT_FREE
    } cond_t;

    // Program steps
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;
    localparam step_t STEP_IDLE   = 3'd0;
    localparam step_t STEP_REDUCE = 3'd1;
    localparam step_t STEP_SUM    = 3'd2;
    localparam step_t STEP_WALK   = 3'd3;
    localparam step_t STEP_DONE   = 3'd4;

    // One control word of the program
    typedef struct packed {
        logic  take;
        cond_t cond;
        op_t   op_true;
        op_t   op_false;
        step_t next_true;
        step_t next_false;
    } ucode_t;

    // Control from sequencer to datapath
    typedef struct packed {
        logic take;
        op_t  op;
    } ctrl_t;

    // Status from datapath to sequencer
    typedef struct packed {
        logic k_zero;
        logic m_lt;
        logic rest_gt;
        logic out_free;
    } status_t;

    function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] len;
        if (m < JANUARY || m > MONTHS_PER_YEAR) begin
            len = '0;
        end else if (m == FEBRUARY && leap) begin
            len = LEAP_FEBRUARY;
        end else begin
            len = MONTH_LENGTH[m - JANUARY];
        end
        return len;
    endfunction

endpackage

// File: rtl/core/gdad_stream_if.sv
interface gdad_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/gdad_sequencer.sv
module gdad_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  gdad_pkg::status_t status,
    output gdad_pkg::ctrl_t   ctrl
);
    import gdad_pkg::*;

    step_t  upc_reg;
    step_t  upc_next;
    ucode_t word;
    logic   hit;

    // Program table
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        unique case (step)
            STEP_IDLE: w = '{take: 1'b1, cond: C_IN_VALID,
                             op_true: OP_LOAD, op_false: OP_NONE,
                             next_true: STEP_REDUCE, next_false: STEP_IDLE};
            STEP_REDUCE: w = '{take: 1'b0, cond: C_K_ZERO,
                             op_true: OP_REDUCE, op_false: OP_REDUCE,
                             next_true: STEP_SUM, next_false: STEP_REDUCE};
            STEP_SUM: w = '{take: 1'b0, cond: C_M_LT,
                             op_true: OP_SUM_ADD, op_false: OP_SUM_END,
                             next_true: STEP_SUM, next_false: STEP_WALK};
            STEP_WALK: w = '{take: 1'b0, cond: C_REST_GT,
                             op_true: OP_WALK, op_false: OP_NONE,
                             next_true: STEP_WALK, next_false: STEP_DONE};
            STEP_DONE: w = '{take: 1'b0, cond: C_OUT_FREE,
                             op_true: OP_EMIT, op_false: OP_NONE,
                             next_true: STEP_IDLE, next_false: STEP_DONE};
            default: w = '{take: 1'b0, cond: C_IN_VALID,
                             op_true: OP_NONE, op_false: OP_NONE,
                             next_true: STEP_IDLE, next_false: STEP_IDLE};
        endcase
        return w;
    endfunction

    // Fetch and select the branch condition
    always_comb
    begin
        word = ucode_rom(upc_reg);
        case (word.cond)
            C_IN_VALID: hit = in_valid;
            C_K_ZERO:   hit = status.k_zero;
            C_M_LT:     hit = status.m_lt;
            C_REST_GT:  hit = status.rest_gt;
            C_OUT_FREE: hit = status.out_free;
            default:    hit = 1'b0;
        endcase
        ctrl.take = word.take;
        ctrl.op   = hit ? word.op_true : word.op_false;
        upc_next  = hit ? word.next_true : word.next_false;
    end

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            upc_reg <= STEP_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

// File: rtl/core/gdad_datapath.sv
module gdad_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  gdad_pkg::ctrl_t    ctrl,
    input  gdad_pkg::request_t req,
    input  logic               out_ready,
    output gdad_pkg::status_t  status,
    output logic               out_valid,
    output gdad_pkg::result_t  out_payload
);
    import gdad_pkg::*;

    logic [REST_W-1:0]       rest_reg,   rest_next;
    logic [MONTH_W-1:0]      month_reg,  month_next;
    logic [MONTH_W-1:0]      target_reg, target_next;
    logic [YEAR_W-1:0]       year_reg,   year_next;
    logic [START_YEAR_W-1:0] ymod_reg,   ymod_next;
    logic [SHIFT_W-1:0]      k_reg,      k_next;
    logic [QUOT_W-1:0]       quot_reg,   quot_next;
    result_t                 out_reg,    out_next;
    logic                    out_valid_reg, out_valid_next;

    logic                    leap;
    logic [DAY_W-1:0]        len;
    logic [PROD_W-1:0]       recip_prod;
    logic [START_YEAR_W-1:0] cycle_sub;

    // Leap test on the year modulo 400, and the year reduction products
    always_comb
    begin
        leap = (ymod_reg == '0) ||
               (ymod_reg[1:0] == 2'b00 && ymod_reg != 15'd100 &&
                ymod_reg != 15'd200 && ymod_reg != 15'd300);
        len  = days_in_month(month_reg, leap);
        recip_prod = {{(PROD_W-START_YEAR_W+YEAR_PRESHIFT){1'b0}},
                      ymod_reg[START_YEAR_W-1:YEAR_PRESHIFT]} *
                     {{(PROD_W-RECIP_W){1'b0}}, RECIP_25};
        cycle_sub  = {{(START_YEAR_W-QUOT_W){1'b0}}, quot_reg} *
                     START_YEAR_W'(CYCLE_YEARS);
        status.k_zero   = (k_reg == '0);
        status.m_lt     = (month_reg < target_reg);
        status.rest_gt  = (rest_reg > {{(REST_W-DAY_W){1'b0}}, len});
        status.out_free = !out_valid_reg || out_ready;
    end

    // Execute the selected operation
    always_comb
    begin
        rest_next      = rest_reg;
        month_next     = month_reg;
        target_next    = target_reg;
        year_next      = year_reg;
        ymod_next      = ymod_reg;
        k_next         = k_reg;
        quot_next      = quot_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (ctrl.op)
            OP_LOAD:
            begin
                rest_next   = {{(REST_W-DAY_W){1'b0}}, req.start_day} +
                              {{(REST_W-ADD_W){1'b0}}, req.days_to_add};
                month_next  = JANUARY;
                target_next = req.start_month;
                year_next   = {{(YEAR_W-START_YEAR_W){1'b0}}, req.start_year};
                ymod_next   = req.start_year;
                k_next      = SHIFT_START;
            end
            OP_REDUCE:
            begin
                // First step forms the number of whole cycles, second takes them off
                if (k_reg != '0) begin
                    quot_next = recip_prod[PROD_W-1:RECIP_SHIFT];
                end else begin
                    ymod_next = ymod_reg - cycle_sub;
                end
                k_next = k_reg - 1'b1;
            end
            OP_SUM_ADD:
            begin
                rest_next  = rest_reg + {{(REST_W-DAY_W){1'b0}}, len};
                month_next = month_reg + 1'b1;
            end
            OP_SUM_END:
            begin
                month_next = JANUARY;
            end
            OP_WALK:
            begin
                rest_next = rest_reg - {{(REST_W-DAY_W){1'b0}}, len};
                if (month_reg >= MONTHS_PER_YEAR) begin
                    month_next = JANUARY;
                    year_next  = year_reg + 1'b1;
                    ymod_next  = (ymod_reg == CYCLE_LAST) ? '0 : ymod_reg + 1'b1;
                end else begin
                    month_next = month_reg + 1'b1;
                end
            end
            OP_EMIT:
            begin
                out_next.result_day   = rest_reg[DAY_W-1:0];
                out_next.result_month = month_reg;
                out_next.result_year  = year_reg;
                out_valid_next        = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Hold the working registers
    always_ff @(posedge clk)
    begin
        rest_reg   <= rest_next;
        month_reg  <= month_next;
        target_reg <= target_next;
        year_reg   <= year_next;
        ymod_reg   <= ymod_next;
        k_reg      <= k_next;
        quot_reg   <= quot_next;
        out_reg    <= out_next;
    end

    // Track the pending result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_payload = out_reg;

endmodule

// File: rtl/core/gregorian_date_add_days.sv
// Adds a day count to a Gregorian date. One request is taken at a time and
// gives one result. A request is accepted, the year is reduced modulo 400 in
// two steps, the lengths of the months before the start are summed, the
// months are walked one month per cycle, and the result register is written;
// that write waits while the previous result still sits in the output
// register. The time taken is set mostly by the month walk. The result sits
// in an output register, so the next request is accepted while it waits.
// Days past the end of a month roll forward, day zero is the day before the
// first (but stays day zero for a January start with nothing added), and
// months above twelve count the whole starting year.
module gregorian_date_add_days (
    input  logic       clk,
    input  logic       rst_n,
    gdad_stream_if.sink   request,
    gdad_stream_if.source result
);
    import gdad_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    gdad_sequencer u_sequencer (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .status   (status),
        .ctrl     (ctrl)
    );

    gdad_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .req         (request.payload),
        .out_ready   (result.ready),
        .status      (status),
        .out_valid   (result.valid),
        .out_payload (result.payload)
    );

    assign request.ready = ctrl.take;

endmodule
